@@ design/wlst_pkg.sv @@
// Package for the wear-level slot tracker.
// Holds the payload structs, command codes, controller states and the
// controller/datapath interface structs. No dependencies.
package wlst_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int CNT_W     = 32;
    localparam int SLOT_W    = 8;
    localparam int CFG_W     = 5;
    localparam int CMD_W     = 2;

    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MARK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd2;

    localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(NUM_SLOTS);

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count_value;
    } t_in;

    typedef struct packed {
        logic [3:0]       least_worn_slot;
        logic [CNT_W-1:0] spread;
        logic             slot_accepted;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic update;
        logic scan_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic n_zero;
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage

@@ design/wlst_ctrl.sv @@
// Controller for the wear-level slot tracker.
// Sequences capture, update, scan and result load. Uses wlst_pkg.
module wlst_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  wlst_pkg::t_dp_sts i_sts,
    output wlst_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);

    wlst_pkg::t_state r_state;
    wlst_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wlst_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wlst_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = wlst_pkg::ST_UPDATE;
                end
            end
            wlst_pkg::ST_UPDATE: begin
                n_state = i_sts.n_zero ? wlst_pkg::ST_DONE : wlst_pkg::ST_SCAN;
            end
            wlst_pkg::ST_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = wlst_pkg::ST_DONE;
                end
            end
            wlst_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = wlst_pkg::ST_IDLE;
                end
            end
            default: n_state = wlst_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            wlst_pkg::ST_IDLE: begin
                o_busy        = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            wlst_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            wlst_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            wlst_pkg::ST_DONE: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: o_busy = 1'b1;
        endcase
    end

endmodule

@@ design/wlst_dp.sv @@
// Datapath for the wear-level slot tracker.
// Holds the count table, slot register, scan registers and result register.
// Uses wlst_pkg.
module wlst_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wlst_pkg::t_dp_cmd                i_cmd,
    output wlst_pkg::t_dp_sts                o_sts,
    input  wlst_pkg::t_in                    i_in_data,
    input  logic                             i_cfg_we,
    input  logic [wlst_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output wlst_pkg::t_out                   o_out_data
);

    logic [wlst_pkg::CNT_W-1:0] r_counts [wlst_pkg::NUM_SLOTS];
    logic [wlst_pkg::CFG_W-1:0] r_slots;
    wlst_pkg::t_in              r_item;
    logic [wlst_pkg::IDX_W-1:0] r_idx;
    logic [wlst_pkg::IDX_W-1:0] r_best;
    logic [wlst_pkg::CNT_W-1:0] r_lo;
    logic [wlst_pkg::CNT_W-1:0] r_hi;
    logic                       r_acc;
    logic                       r_out_valid;
    wlst_pkg::t_out             r_out;

    logic [wlst_pkg::CFG_W-1:0] n_active;
    logic [wlst_pkg::IDX_W-1:0] rd_addr;
    logic [wlst_pkg::CNT_W-1:0] rd_data;
    logic [wlst_pkg::CNT_W-1:0] n_count;
    logic                       apply;

    assign n_active = (r_slots > wlst_pkg::SLOTS_RESET) ? wlst_pkg::SLOTS_RESET : r_slots;
    assign rd_addr  = i_cmd.scan_step ? r_idx : r_item.slot[wlst_pkg::IDX_W-1:0];
    assign rd_data  = r_counts[rd_addr];
    assign apply    = ((r_item.command == wlst_pkg::CMD_MARK)
                       || (r_item.command == wlst_pkg::CMD_LOAD))
                      && (r_item.slot < wlst_pkg::SLOT_W'(n_active));

    always_comb begin
        if (r_item.command == wlst_pkg::CMD_LOAD) begin
            n_count = r_item.count_value;
        end else if (rd_data == '1) begin
            n_count = rd_data;
        end else begin
            n_count = rd_data + wlst_pkg::CNT_W'(1);
        end
    end

    assign o_sts.n_zero    = (n_active == '0);
    assign o_sts.scan_last = (wlst_pkg::CFG_W'(r_idx) == n_active - wlst_pkg::CFG_W'(1));
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= wlst_pkg::SLOTS_RESET;
        end else if (i_cfg_we) begin
            r_slots <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < wlst_pkg::NUM_SLOTS; k++) begin
                r_counts[k] <= '0;
            end
        end else if (i_cmd.update && apply) begin
            r_counts[rd_addr] <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.update) begin
            r_acc  <= apply;
            r_idx  <= '0;
            r_best <= '0;
            r_lo   <= '0;
            r_hi   <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + wlst_pkg::IDX_W'(1);
            if (r_idx == '0) begin
                r_lo <= rd_data;
                r_hi <= rd_data;
            end else begin
                if (rd_data < r_lo) begin
                    r_lo   <= rd_data;
                    r_best <= r_idx;
                end
                if (rd_data > r_hi) begin
                    r_hi <= rd_data;
                end
            end
        end
        if (i_cmd.load_out) begin
            r_out.least_worn_slot <= 4'(r_best);
            r_out.spread          <= r_hi - r_lo;
            r_out.slot_accepted   <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ design/wear_level_slot_tracker.sv @@
// Top level of the wear-level slot tracker.
// Joins wlst_ctrl and wlst_dp. Uses wlst_pkg.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_in_data  (t_in)
//   out      output     o_out_valid / i_out_stall o_out_data (t_out)
//   cfg      input      i_cfg_we                  i_cfg_wdata (slots_in_use)
//
// From input transfer to result transfer, an item passes a table update, a scan of each
// active slot through the single table read port (skipped with no active slot), a result
// load and the output register. The next input is taken at the earliest on the same edge
// as the earliest result transfer.
// Reset is synchronous; it clears the table and sets 16 slots in use.
// A result waits in the output register while the next item is accepted; the
// result load holds while that register is still stalled.
module wear_level_slot_tracker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  wlst_pkg::t_in              i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output wlst_pkg::t_out             o_out_data,
    input  logic                       i_cfg_we,
    input  logic [wlst_pkg::CFG_W-1:0] i_cfg_wdata
);

    wlst_pkg::t_dp_cmd dp_cmd;
    wlst_pkg::t_dp_sts dp_sts;

    wlst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_busy     (o_in_stall)
    );

    wlst_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ design/wlst_checker.sv @@
// Port checker for the wear-level slot tracker, bound to the top level.
// Uses wlst_pkg.
module wlst_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input wlst_pkg::t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled result changed");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again while item in work");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

endmodule

bind wear_level_slot_tracker wlst_checker u_wlst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

@@ dv/wear_level_slot_tracker_tb.sv @@
// Testbench for wear_level_slot_tracker: a table model predicts the least-worn slot, the spread
// and the accept flag for every command, and a scoreboard checks each result in order.
// Depends on wlst_pkg and the wear_level_slot_tracker RTL only.
module wear_level_slot_tracker_tb;
    import wlst_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    class least_worn_checker;
        logic [CNT_W-1:0] wear[NUM_SLOTS];
        logic [CFG_W-1:0] slots_in_use;
        t_out             pending_picks[$];
        int unsigned      mismatch_count;

        function new();
            foreach (wear[i]) wear[i] = '0;
            slots_in_use   = SLOTS_RESET;
            mismatch_count = 0;
        endfunction

        function int unsigned active_slots();
            return (slots_in_use > NUM_SLOTS) ? NUM_SLOTS : slots_in_use;
        endfunction

        function void set_slots(logic [CFG_W-1:0] value);
            slots_in_use = value;
        endfunction

        function void note_command(t_in cmd);
            int unsigned      n;
            int unsigned      best;
            logic [CNT_W-1:0] lo;
            logic [CNT_W-1:0] hi;
            t_out             pick;
            n    = active_slots();
            best = 0;
            lo   = '0;
            hi   = '0;
            pick.slot_accepted = 1'b0;
            if ((cmd.command == CMD_MARK || cmd.command == CMD_LOAD) && cmd.slot < n) begin
                if (cmd.command == CMD_MARK) begin
                    if (wear[cmd.slot] != '1) wear[cmd.slot] = wear[cmd.slot] + 1'b1;
                end else begin
                    wear[cmd.slot] = cmd.count_value;
                end
                pick.slot_accepted = 1'b1;
            end
            if (n > 0) begin
                lo = wear[0];
                hi = wear[0];
                for (int i = 1; i < n; i++) begin
                    if (wear[i] < lo) begin
                        lo   = wear[i];
                        best = i;
                    end
                    if (wear[i] > hi) hi = wear[i];
                end
            end
            pick.least_worn_slot = best[3:0];
            pick.spread          = hi - lo;
            pending_picks.push_back(pick);
        endfunction

        function void check_pick(t_out got);
            t_out want;
            if (pending_picks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with none pending: slot %0d spread %h acc %b",
                             $realtime, got.least_worn_slot, got.spread, got.slot_accepted);
                return;
            end
            want = pending_picks.pop_front();
            if (got.least_worn_slot !== want.least_worn_slot || got.spread !== want.spread
                    || got.slot_accepted !== want.slot_accepted) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: mismatch: exp slot %0d spread %h acc %b,",
                             $realtime, want.least_worn_slot, want.spread,
                             want.slot_accepted,
                             " got slot %0d spread %h acc %b",
                             got.least_worn_slot, got.spread, got.slot_accepted);
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in              i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out             o_out_data;
    logic             i_cfg_we    = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    least_worn_checker sb;
    bit                calm = 1'b0;
    int unsigned       quiet_cycles = 0;

    wear_level_slot_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 14);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_pick(o_out_data);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_command(input logic [CMD_W-1:0] command, input logic [SLOT_W-1:0] slot,
                                input logic [CNT_W-1:0] count_value);
        int unsigned gap;
        t_in         cmd;
        cmd.command     = command;
        cmd.slot        = slot;
        cmd.count_value = count_value;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 14) gap = $urandom_range(1, 24);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_command(cmd);
    endtask

    // hold off until every result has drained
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_picks.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_slots(input logic [CFG_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_slots(value);
    endtask

    task automatic send_random();
        int unsigned      n;
        int unsigned      pick;
        logic [CMD_W-1:0] command;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0] value;
        n    = sb.active_slots();
        pick = $urandom_range(0, 99);
        if (pick < 45)      command = CMD_MARK;
        else if (pick < 70) command = CMD_LOAD;
        else if (pick < 90) command = CMD_QUERY;
        else                command = CMD_SPARE;
        if (n > 0 && $urandom_range(0, 99) < 85) slot = SLOT_W'($urandom_range(0, n - 1));
        else                                      slot = SLOT_W'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: value = $urandom_range(0, 12);
            4, 5:       value = 32'hFFFF_FFFF - $urandom_range(0, 2);
            default:    value = $urandom();
        endcase
        send_command(command, slot, value);
    endtask

    initial begin
        int unsigned phase_cfg[9];
        int unsigned phase_len[9];
        sb = new();
        phase_cfg = '{16, 1, 31, 0, 9, 17, 2, 16, 0};
        phase_len = '{120, 40, 120, 10, 100, 60, 40, 150, 110};
        phase_cfg[8] = $urandom_range(0, 31);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_slots(5'd16);
        send_command(CMD_QUERY, 8'hFF, 32'hFFFF_FFFF);
        send_command(CMD_MARK, 8'd0, 32'h0);
        send_command(CMD_MARK, 8'd15, 32'h0);
        send_command(CMD_MARK, 8'd16, 32'h0);
        send_command(CMD_LOAD, 8'd7, 32'hFFFF_FFFF);
        send_command(CMD_MARK, 8'd7, 32'h0);
        send_command(CMD_LOAD, 8'd255, 32'h0);
        send_command(CMD_SPARE, 8'd1, 32'h5);
        send_command(CMD_LOAD, 8'd7, 32'h0);
        send_command(CMD_LOAD, 8'd0, 32'h0);
        send_command(CMD_LOAD, 8'd2, 32'hFFFF_FFFE);
        send_command(CMD_LOAD, 8'd15, 32'h1);

        write_slots(5'd31);
        send_command(CMD_MARK, 8'd15, 32'h0);
        send_command(CMD_MARK, 8'd16, 32'h0);
        write_slots(5'd0);
        send_command(CMD_QUERY, 8'd0, 32'h0);
        send_command(CMD_MARK, 8'd0, 32'h0);
        send_command(CMD_LOAD, 8'd0, 32'hAAAA_5555);
        write_slots(5'd1);
        send_command(CMD_QUERY, 8'd0, 32'h0);
        send_command(CMD_MARK, 8'd0, 32'h0);
        send_command(CMD_LOAD, 8'd1, 32'h1234_5678);

        foreach (phase_cfg[p]) begin
            write_slots(phase_cfg[p][CFG_W-1:0]);
            calm = (p == 7);
            repeat (phase_len[p]) send_random();
        end
        calm = 1'b0;

        drain();
        repeat (30) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending_picks.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

@@ files.f @@
design/wlst_pkg.sv
design/wlst_ctrl.sv
design/wlst_dp.sv
design/wear_level_slot_tracker.sv
design/wlst_checker.sv
dv/wear_level_slot_tracker_tb.sv
